// ----- sv/assert_macros.svh -----
// Assertion macros shared by the generator protection RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/gpcl_pkg.sv -----
// Package for the generator protection and contactor logic.
// Holds sizes, register codes, reset values and the lane types; no dependencies.
package gpcl_pkg;

	localparam int NUM_GEN  = 5;
	localparam int NUM_MAIN = 4;
	localparam int AUX_GEN  = 4;
	localparam int TICK_MS  = 10;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_FREQ_MIN    = 3'd0;
	localparam logic [2:0] REG_FREQ_MAX    = 3'd1;
	localparam logic [2:0] REG_VOLT_MIN    = 3'd2;
	localparam logic [2:0] REG_VOLT_MAX    = 3'd3;
	localparam logic [2:0] REG_BUS_ON_MIN  = 3'd4;
	localparam logic [2:0] REG_FAULT_DELAY = 3'd5;

	// Reset values
	localparam logic [15:0] FREQ_MIN_RST    = 16'd5920;
	localparam logic [15:0] FREQ_MAX_RST    = 16'd6512;
	localparam logic [15:0] VOLT_MIN_RST    = 16'd6656;
	localparam logic [15:0] VOLT_MAX_RST    = 16'd8256;
	localparam logic [15:0] BUS_ON_MIN_RST  = 16'd1152;
	localparam int          FAULT_DELAY_INT = (6500 + TICK_MS - 1) / TICK_MS;
	localparam logic [15:0] FAULT_DELAY_RST = FAULT_DELAY_INT[15:0];

	// Switch bit positions
	localparam int SW_AUX       = 4;
	localparam int SW_LEFT_TIE  = 5;
	localparam int SW_RIGHT_TIE = 6;

	// Contactor bit positions
	localparam int CB_K1  = 0;
	localparam int CB_K21 = 1;
	localparam int CB_K31 = 2;
	localparam int CB_K41 = 3;
	localparam int CB_LK4 = 4;
	localparam int CB_LK5 = 5;
	localparam int CB_LK6 = 6;
	localparam int CB_PK4 = 7;
	localparam int CB_PK5 = 8;
	localparam int CB_PK6 = 9;
	localparam int CB_CHL = 10;
	localparam int CB_CHP = 11;

	// Protection windows and delay
	typedef struct packed {
		logic [15:0] freq_min;
		logic [15:0] freq_max;
		logic [15:0] volt_min;
		logic [15:0] volt_max;
		logic [15:0] fault_delay;
	} prot_cfg_t;

	// What one generator lane reports for the current item
	typedef struct packed {
		logic ready;
		logic trip;
		logic exc;
	} lane_res_t;

endpackage

// ----- sv/gpcl_lane.sv -----
// One generator protection lane: window checks, voltage fault timer, trip latch
// and excitation state. Depends on gpcl_pkg.
module gpcl_lane import gpcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [31:0] sample,
	input  prot_cfg_t   cfg,
	input  logic        enable,
	output lane_res_t   res
);

	logic        trip_q;
	logic        exc_q;
	logic [15:0] timer_q;

	logic [15:0] freq;
	logic [15:0] volt;
	logic        freq_ok;
	logic        volt_ok;
	logic        trip_set;
	logic        rdy;
	logic [15:0] timer_d;

	assign freq    = sample[31:16];
	assign volt    = sample[15:0];
	assign freq_ok = (freq >= cfg.freq_min) && (freq <= cfg.freq_max);
	assign volt_ok = (volt >= cfg.volt_min) && (volt <= cfg.volt_max);

	// Protection decision on the state from before this item
	always_comb begin
		trip_set = 1'b0;
		timer_d  = timer_q;
		rdy      = 1'b0;
		if (trip_q) begin
			timer_d = '0;
		end else if (!freq_ok) begin
			trip_set = 1'b1;
		end else if (volt_ok) begin
			timer_d = '0;
			rdy     = exc_q;
		end else if (timer_q >= cfg.fault_delay) begin
			trip_set = 1'b1;
		end else begin
			timer_d = timer_q + 16'd1;
			rdy     = exc_q;
		end
	end

	// Excitation follows bus and switch; dropping it clears the trip
	assign res = '{ready: rdy, trip: enable & (trip_q | trip_set), exc: enable};

	// Advance the lane state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_q  <= 1'b0;
			exc_q   <= 1'b0;
			timer_q <= '0;
		end else if (step) begin
			trip_q  <= res.trip;
			exc_q   <= res.exc;
			timer_q <= timer_d;
		end
	end

endmodule

// ----- sv/gpcl_merge.sv -----
// Merging stage: failure lamps and contactor pattern from lane readiness,
// bus state, tie switches and disconnect flags. Depends on gpcl_pkg.
module gpcl_merge import gpcl_pkg::*; (
	input  logic [NUM_GEN-1:0]  ready,
	input  logic                left_up,
	input  logic                right_up,
	input  logic [6:0]          sw,
	input  logic [NUM_MAIN-1:0] disc,
	output logic [NUM_MAIN-1:0] lamps,
	output logic [11:0]         contactors
);

	logic k1, k21, k31, k41, lk4, lk5, pk4, pk5, chl, chp;
	logic [NUM_MAIN-1:0] bus_up;

	// Main generators 1 and 2 sit on the left bus, 3 and 4 on the right
	assign bus_up = {right_up, right_up, left_up, left_up};
	assign lamps  = ~(bus_up & ready[NUM_MAIN-1:0] & ~disc);

	// Tie switches take the line contactors over
	always_comb begin
		k1  = ready[0];
		k21 = ready[1];
		k31 = ready[2];
		k41 = ready[3];
		lk4 = 1'b0;
		lk5 = 1'b0;
		pk4 = 1'b0;
		pk5 = 1'b0;
		chl = 1'b0;
		chp = 1'b0;
		if (sw[SW_LEFT_TIE]) begin
			k1  = 1'b0;
			k21 = 1'b0;
			if (ready[1]) begin
				lk4 = 1'b1;
				chl = 1'b1;
			end else if (ready[0]) begin
				lk4 = 1'b1;
				lk5 = 1'b1;
				chl = 1'b1;
			end
		end
		if (sw[SW_RIGHT_TIE]) begin
			k31 = 1'b0;
			k41 = 1'b0;
			if (ready[2]) begin
				pk4 = 1'b1;
				chp = 1'b1;
			end else if (ready[3]) begin
				pk4 = 1'b1;
				pk5 = 1'b1;
				chp = 1'b1;
			end
		end
	end

	// Pack the contactor word
	always_comb begin
		contactors         = '0;
		contactors[CB_K1]  = k1;
		contactors[CB_K21] = k21;
		contactors[CB_K31] = k31;
		contactors[CB_K41] = k41;
		contactors[CB_LK4] = lk4;
		contactors[CB_LK5] = lk5;
		contactors[CB_LK6] = k1 & ~k21;
		contactors[CB_PK4] = pk4;
		contactors[CB_PK5] = pk5;
		contactors[CB_PK6] = ~k31 & k41;
		contactors[CB_CHL] = chl;
		contactors[CB_CHP] = chp;
	end

endmodule

// ----- sv/generator_protection_contactor_logic.sv -----
// Top level of the generator protection and contactor logic.
// Depends on gpcl_pkg, gpcl_lane, gpcl_merge and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick item: five generator
//   samples, two bus voltages, panel switches and disconnect flags.
//   Output channel (out_valid/out_ready) returns one result item per tick:
//   readiness, failure lamps, excitation enables, trip flags and contactors.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index at the
//   clock edge; unknown indexes are ignored. Write only while idle.
//   Output timing: a result is registered and appears in the cycle after its item is accepted.
//   Throughput: one item per cycle while out_ready is high; the five lanes and
//   the merge stage are combinational; the output register sets the pace.
//   Stall: while a result waits and out_ready is low, in_ready is low; the
//   item is taken in the cycle the waiting result is taken.
//   Reset (arst_n low): trips, excitation and fault timers clear, registers
//   return to their default windows, and the output register empties.
module generator_protection_contactor_logic import gpcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] gen_sample_a,
	input  logic [31:0] gen_sample_b,
	input  logic [31:0] gen_sample_c,
	input  logic [31:0] gen_sample_d,
	input  logic [31:0] gen_sample_aux,
	input  logic [15:0] left_bus_voltage,
	input  logic [15:0] right_bus_voltage,
	input  logic [6:0]  switch_bits,
	input  logic [3:0]  disconnect_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  gen_ready,
	output logic [3:0]  fail_lamps,
	output logic [4:0]  excitation_enables,
	output logic [4:0]  trip_flags,
	output logic [11:0] contactor_bits
);

	prot_cfg_t   cfg_q;
	logic [15:0] bus_on_min_q;

	logic                step;
	logic                left_up;
	logic                right_up;
	logic [31:0]         samples [NUM_GEN];
	logic [NUM_GEN-1:0]  enables;
	lane_res_t           lane_res [NUM_GEN];
	logic [NUM_GEN-1:0]  ready_vec;
	logic [NUM_GEN-1:0]  trip_vec;
	logic [NUM_GEN-1:0]  exc_vec;
	logic [NUM_MAIN-1:0] lamps;
	logic [11:0]         contactors;

	logic                valid_q;
	logic [NUM_GEN-1:0]  ready_q;
	logic [NUM_MAIN-1:0] lamps_q;
	logic [NUM_GEN-1:0]  exc_q;
	logic [NUM_GEN-1:0]  trip_q;
	logic [11:0]         cont_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_min    <= FREQ_MIN_RST;
			cfg_q.freq_max    <= FREQ_MAX_RST;
			cfg_q.volt_min    <= VOLT_MIN_RST;
			cfg_q.volt_max    <= VOLT_MAX_RST;
			cfg_q.fault_delay <= FAULT_DELAY_RST;
			bus_on_min_q      <= BUS_ON_MIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FREQ_MIN:    cfg_q.freq_min    <= cfg_data;
				REG_FREQ_MAX:    cfg_q.freq_max    <= cfg_data;
				REG_VOLT_MIN:    cfg_q.volt_min    <= cfg_data;
				REG_VOLT_MAX:    cfg_q.volt_max    <= cfg_data;
				REG_BUS_ON_MIN:  bus_on_min_q      <= cfg_data;
				REG_FAULT_DELAY: cfg_q.fault_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take an item whenever the output register is free or being emptied
	assign in_ready = !valid_q || out_ready;
	assign step     = in_valid && in_ready;

	// Bus state and per-generator excitation requests
	assign left_up  = left_bus_voltage >= bus_on_min_q;
	assign right_up = right_bus_voltage >= bus_on_min_q;
	assign enables  = {left_up & switch_bits[SW_AUX],
	                   right_up & switch_bits[3], right_up & switch_bits[2],
	                   left_up & switch_bits[1], left_up & switch_bits[0]};

	assign samples[0] = gen_sample_a;
	assign samples[1] = gen_sample_b;
	assign samples[2] = gen_sample_c;
	assign samples[3] = gen_sample_d;
	assign samples[AUX_GEN] = gen_sample_aux;

	// One protection lane per generator
	for (genvar g = 0; g < NUM_GEN; g++) begin : g_lane
		gpcl_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.sample (samples[g]),
			.cfg    (cfg_q),
			.enable (enables[g]),
			.res    (lane_res[g])
		);
		assign ready_vec[g] = lane_res[g].ready;
		assign trip_vec[g]  = lane_res[g].trip;
		assign exc_vec[g]   = lane_res[g].exc;
	end

	// Combine the lanes into lamps and contactors
	gpcl_merge u_merge (
		.ready      (ready_vec),
		.left_up    (left_up),
		.right_up   (right_up),
		.sw         (switch_bits),
		.disc       (disconnect_flags),
		.lamps      (lamps),
		.contactors (contactors)
	);

	// Output register: hold while stalled, load on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ready_q <= ready_vec;
			lamps_q <= lamps;
			exc_q   <= exc_vec;
			trip_q  <= trip_vec;
			cont_q  <= contactors;
		end
	end

	assign out_valid          = valid_q;
	assign gen_ready          = ready_q;
	assign fail_lamps         = lamps_q;
	assign excitation_enables = exc_q;
	assign trip_flags         = trip_q;
	assign contactor_bits     = cont_q;

`include "assert_macros.svh"

	`ASSERT_CLK(a_ready_not_tripped, !out_valid || ~|(gen_ready & trip_flags), "ready while tripped")
	`ASSERT_CLK(a_trip_exc, !out_valid || ~|(trip_flags & ~excitation_enables), "trip w/o excitation")
	`ASSERT_CLK(a_stall_blocks_input, !out_valid || out_ready || !in_ready, "input open in stall")
	`ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid, "item gave no result")

endmodule
